@@ rtl/pdbc_pkg.sv @@
// Shared types, constants and register codes for the plane distance band classifier.
`default_nettype none

package pdbc_pkg;

    // Fraction bits of the fixed-point point and distance format
    localparam int unsigned FRAC_BITS = 16;

    // Object window bounds: 0.01 m and 0.2 m, rounded down
    localparam logic [31:0] OBJ_LO = 32'((64'd1 << FRAC_BITS) / 100);
    localparam logic [31:0] OBJ_HI = 32'((64'd1 << FRAC_BITS) / 5);

    // Register reset values: 0.015 m half width and 0.025 m step at 16 fraction bits
    localparam logic [15:0] HALF_RESET = 16'd983;
    localparam logic [15:0] STEP_RESET = 16'd1638;

    // Divider pipeline shape: quotient bits split over stages
    localparam int unsigned QUOT_BITS          = 32;
    localparam int unsigned DIV_BITS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES         = QUOT_BITS / DIV_BITS_PER_STAGE;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_NORMAL_X       = 3'd0,
        CFG_NORMAL_Y       = 3'd1,
        CFG_NORMAL_Z       = 3'd2,
        CFG_PLANE_OFFSET   = 3'd3,
        CFG_NORMAL_LENGTH  = 3'd4,
        CFG_BAND_HALF      = 3'd5,
        CFG_GRID_STEP      = 3'd6
    } cfg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [47:0] plane_offset;
        logic        [31:0] normal_length;
        logic        [15:0] band_half_width;
        logic        [15:0] grid_step;
    } cfg_t;

    // Input point, x in the lowest bits
    typedef struct packed {
        logic signed [31:0] point_z;
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
    } point_t;

    // Division work word: partial remainder, dividend bits becoming quotient, overflow mark
    typedef struct packed {
        logic        sat;
        logic [31:0] rem;
        logic [31:0] low;
    } div_t;

    // Result word, distance in the lowest bits
    typedef struct packed {
        logic        object_hit;
        logic        face_three;
        logic        face_two;
        logic        face_one;
        logic        level_three;
        logic        level_two;
        logic        level_one;
        logic [31:0] plane_distance;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/pdbc_mac.sv @@
// Plane equation: three products, wide sum, magnitude and overflow check.
`default_nettype none

module pdbc_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pdbc_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output      logic            in_ready,
    input  wire pdbc_pkg::point_t in_point,
    output      logic            out_valid,
    input  wire logic            out_ready,
    output      pdbc_pkg::div_t   out_word
);
    import pdbc_pkg::*;

    logic               prod_valid_reg;
    logic               sum_valid_reg;
    logic               mag_valid_reg;
    logic               prod_valid_next;
    logic               sum_valid_next;
    logic               mag_valid_next;
    logic               prod_ready;
    logic               sum_ready;
    logic               mag_ready;

    logic signed [63:0] px_reg;
    logic signed [63:0] py_reg;
    logic signed [63:0] pz_reg;
    logic signed [65:0] sum_reg;
    logic signed [65:0] sum_next;
    logic signed [65:0] sum_neg;
    logic        [63:0] mag;
    div_t               word_reg;
    div_t               word_next;

    // Each stage takes a word when empty or when its own word moves on
    assign mag_ready  = !mag_valid_reg  || out_ready;
    assign sum_ready  = !sum_valid_reg  || mag_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    always_comb
    begin
        prod_valid_next = prod_ready ? in_valid       : prod_valid_reg;
        sum_valid_next  = sum_ready  ? prod_valid_reg : sum_valid_reg;
        mag_valid_next  = mag_ready  ? sum_valid_reg  : mag_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
            mag_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            sum_valid_reg  <= sum_valid_next;
            mag_valid_reg  <= mag_valid_next;
        end
    end

    // Stage one: the three signed products
    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
        begin
            px_reg <= $signed(cfg.normal_x) * $signed(in_point.point_x);
            py_reg <= $signed(cfg.normal_y) * $signed(in_point.point_y);
            pz_reg <= $signed(cfg.normal_z) * $signed(in_point.point_z);
        end
    end

    // Stage two: exact sum with the plane offset
    assign sum_next = 66'(px_reg) + 66'(py_reg) + 66'(pz_reg) + 66'($signed(cfg.plane_offset));

    always_ff @(posedge clk)
    begin
        if (sum_ready && prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    // Stage three: magnitude, and flag quotients that overflow 32 bits (zero length too)
    assign sum_neg = -sum_reg;
    assign mag     = sum_reg[65] ? sum_neg[63:0] : sum_reg[63:0];

    always_comb
    begin
        word_next.rem = mag[63:32];
        word_next.low = mag[31:0];
        word_next.sat = (mag[63:32] >= cfg.normal_length);
    end

    always_ff @(posedge clk)
    begin
        if (mag_ready && sum_valid_reg)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = mag_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

@@ rtl/pdbc_div.sv @@
// Pipelined restoring divider: a few quotient bits per stage.
`default_nettype none

module pdbc_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    divisor,
    input  wire logic           in_valid,
    output      logic           in_ready,
    input  wire pdbc_pkg::div_t  in_word,
    output      logic           out_valid,
    input  wire logic           out_ready,
    output      pdbc_pkg::div_t  out_word
);
    import pdbc_pkg::*;

    logic                  valid_reg [DIV_STAGES];
    logic                  stage_in_valid [DIV_STAGES];
    logic                  ready [DIV_STAGES+1];
    div_t                  word_reg [DIV_STAGES];
    div_t                  stage_in [DIV_STAGES];

    // Restoring division steps; the remainder stays below the divisor
    function automatic div_t div_steps(input div_t w, input logic [31:0] dv);
        div_t        r;
        logic [32:0] trial;
        r = w;
        for (int i = 0; i < int'(DIV_BITS_PER_STAGE); i++)
        begin
            trial = {r.rem, r.low[31]};
            r.low = {r.low[30:0], 1'b0};
            if (trial >= {1'b0, dv})
            begin
                trial    = trial - {1'b0, dv};
                r.low[0] = 1'b1;
            end
            r.rem = trial[31:0];
        end
        return r;
    endfunction

    assign ready[DIV_STAGES] = out_ready;
    assign in_ready          = ready[0];

    for (genvar g = 0; g < int'(DIV_STAGES); g++)
    begin : g_stage
        logic valid_next;

        if (g == 0)
        begin : g_first
            assign stage_in[g]       = in_word;
            assign stage_in_valid[g] = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[g]       = word_reg[g-1];
            assign stage_in_valid[g] = valid_reg[g-1];
        end

        assign ready[g]   = !valid_reg[g] || ready[g+1];
        assign valid_next = ready[g] ? stage_in_valid[g] : valid_reg[g];

        // Advance the valid mark
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_next;
            end
        end

        // Hold or load the work word
        always_ff @(posedge clk)
        begin
            if (ready[g] && stage_in_valid[g])
            begin
                word_reg[g] <= div_steps(stage_in[g], divisor);
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_word  = word_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/pdbc_band.sv @@
// Distance saturation, band and object flags, and the output register.
`default_nettype none

module pdbc_band (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pdbc_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire pdbc_pkg::div_t     in_word,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      pdbc_pkg::result_t  out_result
);
    import pdbc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic        [31:0] distance;
    logic signed [33:0] dist_s;
    logic signed [19:0] half_s;
    logic signed [19:0] step_s;
    logic signed [19:0] centre [3];
    logic               level_hit [3];
    logic               face_hit [3];

    function automatic logic open_range(input logic signed [19:0] lo,
                                        input logic signed [33:0] d,
                                        input logic signed [19:0] hi);
        return (34'(lo) < d) && (d < 34'(hi));
    endfunction

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Clamp overflowing quotients to the maximum distance
    assign distance = in_word.sat ? '1 : in_word.low;
    assign dist_s   = $signed({2'b00, distance});
    assign half_s   = $signed({4'b0000, cfg.band_half_width});
    assign step_s   = $signed({4'b0000, cfg.grid_step});

    // Level centres at one, two and three steps
    assign centre[0] = step_s;
    assign centre[1] = step_s <<< 1;
    assign centre[2] = step_s + (step_s <<< 1);

    // Compare against each level band and the gap below it
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            level_hit[k] = open_range(centre[k] - half_s, dist_s, centre[k] + half_s);
            face_hit[k]  = open_range(centre[k] - step_s + half_s, dist_s,
                                      centre[k] - half_s);
        end
    end

    always_comb
    begin
        result_next.plane_distance = distance;
        result_next.level_one      = level_hit[0];
        result_next.level_two      = level_hit[1];
        result_next.level_three    = level_hit[2];
        result_next.face_one       = face_hit[0];
        result_next.face_two       = face_hit[1];
        result_next.face_three     = face_hit[2];
        result_next.object_hit     = (distance > OBJ_LO) && (distance < OBJ_HI);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load the output word when the slot frees
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

@@ rtl/plane_distance_band_classifier_unit.sv @@
// Top level of the plane distance band classifier: register file and pipeline.
`default_nettype none

// Takes one point per cycle while the output is not held, and returns its
// distance to the configured plane with seven band flags. The point passes
// through one product stage, one sum stage, one magnitude stage, eight
// divider stages of four quotient bits each, and the output register.
// Throughput is one word per cycle while the output is not held. Each stage
// holds its word while it is full and the stage after it cannot take it, so
// a stall at the output fills the pipeline and only then lowers s_axis_tready.
// Program the registers only while no point is in flight; a zero normal length
// reads as maximum distance with every flag clear.
module plane_distance_band_classifier_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration writes
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    // Point input
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  wire logic [95:0] s_axis_tdata,
    // Result output
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // plane_distance [31:0], level_one [32], level_two [33], level_three [34],
    // face_one [35], face_two [36], face_three [37], object_hit [38], zero [39]
    output      logic [39:0] m_axis_tdata
);
    import pdbc_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    mac_valid;
    logic    mac_ready;
    div_t    mac_word;
    logic    div_valid;
    logic    div_ready;
    div_t    div_word;
    result_t result;

    // Register writes, sign or zero width taken from the low data bits
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NORMAL_X:      cfg_next.normal_x        = cfg_data[31:0];
                CFG_NORMAL_Y:      cfg_next.normal_y        = cfg_data[31:0];
                CFG_NORMAL_Z:      cfg_next.normal_z        = cfg_data[31:0];
                CFG_PLANE_OFFSET:  cfg_next.plane_offset    = cfg_data;
                CFG_NORMAL_LENGTH: cfg_next.normal_length   = cfg_data[31:0];
                CFG_BAND_HALF:     cfg_next.band_half_width = cfg_data[15:0];
                CFG_GRID_STEP:     cfg_next.grid_step       = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_x        <= '0;
            cfg_reg.normal_y        <= '0;
            cfg_reg.normal_z        <= '0;
            cfg_reg.plane_offset    <= '0;
            cfg_reg.normal_length   <= '0;
            cfg_reg.band_half_width <= HALF_RESET;
            cfg_reg.grid_step       <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pdbc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_point  (point_t'(s_axis_tdata)),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_word  (mac_word)
    );

    pdbc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (cfg_reg.normal_length),
        .in_valid  (mac_valid),
        .in_ready  (mac_ready),
        .in_word   (mac_word),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_word  (div_word)
    );

    pdbc_band u_band (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_word    (div_word),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

`default_nettype wire

@@ rtl/pdbc_checker.sv @@
// Port-level checks for the plane distance band classifier, bound to the top level.
`default_nettype none

module pdbc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import pdbc_pkg::*;

    // A held result word keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result word changed");

    // A saturated distance clears every flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] == 32'hFFFF_FFFF) |-> m_axis_tdata[39:32] == 8'h00)
        else $error("flag set on saturated distance");

    // A level band and the face band just below it never both hold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[32] && m_axis_tdata[35])
                       && !(m_axis_tdata[33] && m_axis_tdata[36])
                       && !(m_axis_tdata[34] && m_axis_tdata[37]))
        else $error("level and face flag both set");

    // The object flag agrees with the distance
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[38] ==
            ((m_axis_tdata[31:0] > OBJ_LO) && (m_axis_tdata[31:0] < OBJ_HI)))
        else $error("object flag disagrees with distance");

endmodule

bind plane_distance_band_classifier_unit pdbc_checker u_pdbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ dv/plane_band_checker.sv @@
// Checker for the plane distance band classifier: predicts and compares every result word.
module plane_band_checker
    import pdbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          band_hits,
    output int          object_hits,
    output int          saturated_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // One point in flight together with the word it must produce
    typedef struct {
        point_t  pt;
        result_t res;
    } awaited_word_t;

    cfg_t          plane_regs;
    awaited_word_t awaited_words[$];

    // Distance to the plane and band flags for one point under the given registers
    function automatic result_t classify_point(input cfg_t r, input point_t p);
        logic signed [127:0] sum;
        logic [127:0]        mag;
        logic [127:0]        quot;
        longint              distance_q;
        longint              half;
        longint              pitch;
        longint              centre;
        longint              obj_lo;
        longint              obj_hi;
        logic [2:0]          level;
        logic [2:0]          face;
        result_t             res;

        res = '0;
        // Degenerate plane: maximum distance, no flags
        if (r.normal_length == 32'd0)
        begin
            res.plane_distance = '1;
            return res;
        end

        // Exact plane equation, then magnitude and truncating division
        sum = longint'($signed(r.normal_x)) * longint'($signed(p.point_x));
        sum = sum + longint'($signed(r.normal_y)) * longint'($signed(p.point_y));
        sum = sum + longint'($signed(r.normal_z)) * longint'($signed(p.point_z));
        sum = sum + longint'($signed(r.plane_offset));
        mag = sum[127] ? -sum : sum;
        quot = mag / {96'd0, r.normal_length};
        res.plane_distance = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];

        // Strict band comparisons on signed bounds, never clipped at zero
        distance_q = res.plane_distance;
        half = r.band_half_width;
        pitch = r.grid_step;
        obj_lo = OBJ_LO;
        obj_hi = OBJ_HI;
        for (int k = 1; k <= 3; k++)
        begin
            centre = k * pitch;
            level[k-1] = (centre - half < distance_q) && (distance_q < centre + half);
            face[k-1] = (centre - pitch + half < distance_q) && (distance_q < centre - half);
        end
        res.level_one   = level[0];
        res.level_two   = level[1];
        res.level_three = level[2];
        res.face_one    = face[0];
        res.face_two    = face[1];
        res.face_three  = face[2];
        res.object_hit  = (obj_lo < distance_q) && (distance_q < obj_hi);
        return res;
    endfunction

    // Track register writes, queue predictions, compare result words
    always @(posedge clk or negedge rst_n)
    begin
        awaited_word_t head;
        awaited_word_t fresh;
        result_t       seen;

        if (!rst_n)
        begin
            plane_regs = '0;
            plane_regs.band_half_width = HALF_RESET;
            plane_regs.grid_step = STEP_RESET;
            awaited_words.delete();
            pending = 0;
        end
        else
        begin
            // Register write: mask to width, drop unknown indexes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NORMAL_X:      plane_regs.normal_x = cfg_data[31:0];
                    CFG_NORMAL_Y:      plane_regs.normal_y = cfg_data[31:0];
                    CFG_NORMAL_Z:      plane_regs.normal_z = cfg_data[31:0];
                    CFG_PLANE_OFFSET:  plane_regs.plane_offset = cfg_data;
                    CFG_NORMAL_LENGTH: plane_regs.normal_length = cfg_data[31:0];
                    CFG_BAND_HALF:     plane_regs.band_half_width = cfg_data[15:0];
                    CFG_GRID_STEP:     plane_regs.grid_step = cfg_data[15:0];
                    default:           ;
                endcase
            end

            // Point word taken: predict its result and queue it at the tail
            if (s_axis_tvalid && s_axis_tready)
            begin
                fresh.pt = s_axis_tdata;
                fresh.res = classify_point(plane_regs, fresh.pt);
                awaited_words = {awaited_words, fresh};
            end

            // Result word taken: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata[38:0];
                results_checked++;
                if (awaited_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result word %h", $realtime, m_axis_tdata);
                end
                else
                begin
                    head = awaited_words.pop_front();
                    if (seen !== head.res || m_axis_tdata[39] !== 1'b0)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] mismatch for point (%0d, %0d, %0d): expected distance %0d flags %b, got distance %0d flags %b",
                                     $realtime, head.pt.point_x, head.pt.point_y,
                                     head.pt.point_z, head.res.plane_distance,
                                     {1'b0, head.res[38:32]}, seen.plane_distance,
                                     m_axis_tdata[39:32]);
                    end
                    if (|head.res[37:32])
                        band_hits++;
                    if (head.res.object_hit)
                        object_hits++;
                    if (head.res.plane_distance == 32'hFFFF_FFFF)
                        saturated_hits++;
                end
            end

            pending = awaited_words.size();
        end
    end

endmodule

@@ dv/tb_plane_distance_band_classifier_unit.sv @@
// Testbench top for the plane distance band classifier: clock, reset, stimulus and verdict.
module tb_plane_distance_band_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pdbc_pkg::*;

    localparam logic [2:0] CFG_SPARE_IDX = 3'd7;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int CALM_PHASE      = 4;
    localparam int IDLE_PCT        = 31;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int          chk_fails;
    int          chk_pending;
    int          chk_results;
    int          chk_band_hits;
    int          chk_object_hits;
    int          chk_saturated;

    bit          calm = 1'b0;
    int          points_sent = 0;
    int          cfg_writes = 0;
    int          settings = 0;

    plane_distance_band_classifier_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    plane_band_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (chk_fails),
        .pending         (chk_pending),
        .results_checked (chk_results),
        .band_hits       (chk_band_hits),
        .object_hits     (chk_object_hits),
        .saturated_hits  (chk_saturated)
    );

    // Free-running clock
    always #5 clk = ~clk;

    // Result side: stall at random except in the calm stretch
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Corner values of a signed 32-bit field
    function automatic logic [31:0] pick_extreme32();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Coordinate range that lands distances around the bands
    function automatic int plane_span(input cfg_t c);
        return 3 * int'(c.grid_step) + 2 * int'(c.band_half_width) + 2000;
    endfunction

    // Draw one plane and band setting of the given kind
    function automatic cfg_t random_plane(input int mode);
        cfg_t        c;
        int unsigned len;
        int          span;
        int          axis;
        longint      shift;

        c = '0;
        case ($urandom_range(6))
            0:
            begin
                c.grid_step = 16'd0;
                c.band_half_width = 16'($urandom_range(0, 4000));
            end
            1:
            begin
                c.grid_step = 16'hFFFF;
                c.band_half_width = 16'hFFFF;
            end
            2:
            begin
                c.grid_step = 16'($urandom_range(1, 6000));
                c.band_half_width = 16'd0;
            end
            3:
            begin
                c.grid_step = 16'($urandom);
                c.band_half_width = 16'($urandom);
            end
            default:
            begin
                c.grid_step = 16'($urandom_range(1, 6000));
                c.band_half_width = 16'($urandom_range(0, c.grid_step));
            end
        endcase
        span = plane_span(c);
        len = $urandom_range(1, 1 << 20);
        shift = longint'(int'($urandom_range(0, 2 * span)) - span) * longint'(len);

        case (mode)
            // One axis carries the whole normal
            0:
            begin
                axis = $urandom_range(2);
                c.normal_x = (axis == 0) ? ($urandom_range(1) ? len : -len) : 32'd0;
                c.normal_y = (axis == 1) ? ($urandom_range(1) ? len : -len) : 32'd0;
                c.normal_z = (axis == 2) ? ($urandom_range(1) ? len : -len) : 32'd0;
                c.plane_offset = 48'(shift);
                c.normal_length = len;
            end
            // Tilted normal with components up to the length
            1:
            begin
                c.normal_x = int'($urandom_range(0, 2 * len)) - int'(len);
                c.normal_y = int'($urandom_range(0, 2 * len)) - int'(len);
                c.normal_z = int'($urandom_range(0, 2 * len)) - int'(len);
                c.plane_offset = 48'(shift);
                c.normal_length = len;
            end
            // Anything goes
            2:
            begin
                c.normal_x = $urandom;
                c.normal_y = $urandom;
                c.normal_z = $urandom;
                c.plane_offset = 48'({$urandom, $urandom});
                c.normal_length = $urandom;
            end
            // Corner values throughout
            3:
            begin
                c.normal_x = pick_extreme32();
                c.normal_y = pick_extreme32();
                c.normal_z = pick_extreme32();
                case ($urandom_range(3))
                    0:       c.plane_offset = 48'h8000_0000_0000;
                    1:       c.plane_offset = 48'h7FFF_FFFF_FFFF;
                    2:       c.plane_offset = 48'd0;
                    default: c.plane_offset = 48'({$urandom, $urandom});
                endcase
                case ($urandom_range(3))
                    0:       c.normal_length = 32'd1;
                    1:       c.normal_length = 32'hFFFF_FFFF;
                    2:       c.normal_length = 32'h8000_0000;
                    default: c.normal_length = $urandom | 32'd1;
                endcase
            end
            // Degenerate plane
            default:
            begin
                c.normal_x = $urandom;
                c.normal_y = $urandom;
                c.normal_z = $urandom;
                c.plane_offset = 48'({$urandom, $urandom});
                c.normal_length = 32'd0;
            end
        endcase
        return c;
    endfunction

    // Draw one point: mostly near the plane, some noise and corners
    function automatic point_t random_point(input int span);
        point_t p;
        int     kind;

        kind = $urandom_range(99);
        if (kind < 65)
        begin
            p.point_x = int'($urandom_range(0, 2 * span)) - span;
            p.point_y = int'($urandom_range(0, 2 * span)) - span;
            p.point_z = int'($urandom_range(0, 2 * span)) - span;
        end
        else if (kind < 85)
        begin
            p.point_x = $urandom;
            p.point_y = $urandom;
            p.point_z = $urandom;
        end
        else
        begin
            p.point_x = $urandom_range(1) ? pick_extreme32() : $urandom;
            p.point_y = $urandom_range(1) ? pick_extreme32() : $urandom;
            p.point_z = $urandom_range(1) ? pick_extreme32() : $urandom;
        end
        return p;
    endfunction

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_writes++;
    endtask

    // Load a whole setting with junk above the width of each register narrower than the data
    task automatic write_all(input cfg_t c);
        write_reg(CFG_NORMAL_X, {16'($urandom), c.normal_x});
        write_reg(CFG_NORMAL_Y, {16'($urandom), c.normal_y});
        write_reg(CFG_NORMAL_Z, {16'($urandom), c.normal_z});
        write_reg(CFG_PLANE_OFFSET, c.plane_offset);
        write_reg(CFG_NORMAL_LENGTH, {16'($urandom), c.normal_length});
        write_reg(CFG_BAND_HALF, {32'($urandom), c.band_half_width});
        write_reg(CFG_GRID_STEP, {32'($urandom), c.grid_step});
        if ($urandom_range(2) == 0)
            write_reg(CFG_SPARE_IDX, 48'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Offer one point word, with random gaps ahead of it
    task automatic send_point(input point_t p);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        points_sent++;
    endtask

    task automatic send_xyz(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        point_t p;

        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        send_point(p);
    endtask

    // Drop valid and hold until every result word is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    // Run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d result words outstanding", chk_pending);
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        cfg_t plane_now;
        int   span;
        int   band_edges[14];

        band_edges = '{1438, 1439, 1837, 1838, 1839, 200, 201, 655, 656, 13106, 13107,
                       -4914, 5114, 32'h8000_0000};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: degenerate plane
        send_xyz(32'd0, 32'd0, 32'd0);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_idle();

        // Horizontal plane, distance equals |z|: walk the band and object edges
        plane_now = '0;
        plane_now.normal_z = 32'd1;
        plane_now.normal_length = 32'd1;
        plane_now.band_half_width = 16'd200;
        plane_now.grid_step = 16'd1638;
        write_all(plane_now);
        foreach (band_edges[i])
            send_xyz($urandom, $urandom, band_edges[i]);
        wait_idle();

        // Corner normals and offset: saturation both ways
        plane_now.normal_x = 32'h8000_0000;
        plane_now.normal_y = 32'h7FFF_FFFF;
        plane_now.normal_z = 32'h8000_0000;
        plane_now.plane_offset = 48'h7FFF_FFFF_FFFF;
        plane_now.normal_length = 32'd1;
        plane_now.band_half_width = 16'hFFFF;
        plane_now.grid_step = 16'hFFFF;
        write_all(plane_now);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_xyz(32'd0, 32'd0, 32'd0);
        wait_idle();

        // Huge length, half wider than the step: bounds below zero
        write_reg(CFG_SPARE_IDX, 48'hFFFF_FFFF_FFFF);
        plane_now = '0;
        plane_now.normal_x = 32'd1;
        plane_now.normal_length = 32'hFFFF_FFFF;
        plane_now.band_half_width = 16'd3000;
        plane_now.grid_step = 16'd1000;
        write_all(plane_now);
        send_xyz(32'h8000_0000, 32'd0, 32'd0);
        send_xyz(32'd0, 32'd0, 32'd0);

        // Random settings, one stretch without any idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            calm = (phase == CALM_PHASE);
            plane_now = random_plane(phase % 5);
            write_all(plane_now);
            span = plane_span(plane_now);
            repeat (ITEMS_PER_PHASE)
                send_point(random_point(span));
        end

        // Drain, then allow for stray words
        wait_idle();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d points over %0d plane settings with %0d register writes",
                 points_sent, settings, cfg_writes);
        $display("%0d results checked: %0d in a band, %0d object hits, %0d saturated",
                 chk_results, chk_band_hits, chk_object_hits, chk_saturated);
        if (chk_pending != 0)
            $display("%0d predicted result words never arrived", chk_pending);
        if (chk_fails == 0 && chk_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pdbc_pkg.sv
rtl/pdbc_mac.sv
rtl/pdbc_div.sv
rtl/pdbc_band.sv
rtl/plane_distance_band_classifier_unit.sv
rtl/pdbc_checker.sv
dv/plane_band_checker.sv
dv/tb_plane_distance_band_classifier_unit.sv
